>>> design/u16m8_pkg.sv
// Shared types, constants and encoding functions for the UTF-16 to modified UTF-8 encoder.
package u16m8_pkg;

   localparam int unsigned U16M8_QUEUE_DEPTH = 2;
   localparam int unsigned U16M8_MAX_BYTES   = 6;

   localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
   localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

   typedef logic [7:0] byte_type;

   // One classified input item: the bytes it produces and how to report them.
   typedef struct packed {
      byte_type [U16M8_MAX_BYTES-1:0] bytes;
      logic [2:0]                     count;
      logic                           last;
      logic                           hit;
      logic [31:0]                    base;
   } qent_type;

   function automatic logic is_high(input logic [15:0] u);
      is_high = (u >= HIGH_SURR_FIRST) && (u <= HIGH_SURR_LAST);
   endfunction

   function automatic logic is_low(input logic [15:0] u);
      is_low = (u >= LOW_SURR_FIRST) && (u <= LOW_SURR_LAST);
   endfunction

   function automatic logic [1:0] unit_len(input logic [15:0] u);
      if (u == 16'h0000) begin
         unit_len = 2'd2;
      end else if (u <= 16'h007F) begin
         unit_len = 2'd1;
      end else if (u <= 16'h07FF) begin
         unit_len = 2'd2;
      end else begin
         unit_len = 2'd3;
      end
   endfunction

   function automatic logic [2:0][7:0] unit_bytes(input logic [15:0] u);
      logic [2:0][7:0] b;
      b = '0;
      if (u == 16'h0000) begin
         b[0] = 8'hC0;
         b[1] = 8'h80;
      end else if (u <= 16'h007F) begin
         b[0] = u[7:0];
      end else if (u <= 16'h07FF) begin
         b[0] = {3'b110, u[10:6]};
         b[1] = {2'b10, u[5:0]};
      end else begin
         b[0] = {4'b1110, u[15:12]};
         b[1] = {2'b10, u[11:6]};
         b[2] = {2'b10, u[5:0]};
      end
      unit_bytes = b;
   endfunction

   function automatic logic [3:0][7:0] pair_bytes(input logic [15:0] hi, input logic [15:0] lo);
      logic [20:0] cp;
      logic [3:0][7:0] b;
      cp = {1'b0, hi[9:0], lo[9:0]} + 21'h10000;
      b[0] = {5'b11110, cp[20:18]};
      b[1] = {2'b10, cp[17:12]};
      b[2] = {2'b10, cp[11:6]};
      b[3] = {2'b10, cp[5:0]};
      pair_bytes = b;
   endfunction

endpackage

>>> design/u16m8_front.sv
// Front end: takes code units, pairs surrogates, checks capacity and builds queue entries.
module u16m8_front
   import u16m8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        q_full,
   output logic        q_push,
   output qent_type    q_data
);

   logic [31:0] cap_ff;
   logic [15:0] held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic [31:0] bw_ff, bw_in;
   logic        stop_ff, stop_in;

   logic        accept;
   logic        pair;
   logic        hold_cur;
   logic [1:0]  n_cur;
   logic [2:0]  need_all;
   logic [2:0]  cnt;
   logic [32:0] sum_all, sum_held, cap_ext;
   logic        fit_all, fit_held;
   logic [2:0][7:0] cur_b, held_b;
   logic [3:0][7:0] pair_b;
   byte_type [U16M8_MAX_BYTES-1:0] bytes;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   assign pair     = held_valid_ff && is_low(req_code_unit);
   assign hold_cur = is_high(req_code_unit) && !req_last_unit;
   assign n_cur    = unit_len(req_code_unit);

   always_comb begin
      if (pair) begin
         need_all = 3'd4;
      end else begin
         need_all = (held_valid_ff ? 3'd3 : 3'd0) + (hold_cur ? 3'd0 : {1'b0, n_cur});
      end
   end

   // Both checks start from the same count so the adders sit side by side.
   assign cap_ext  = {1'b0, cap_ff};
   assign sum_all  = {1'b0, bw_ff} + 33'(need_all);
   assign sum_held = {1'b0, bw_ff} + 33'd3;
   assign fit_all  = sum_all <= cap_ext;
   assign fit_held = sum_held <= cap_ext;

   always_comb begin
      cnt           = 3'd0;
      stop_in       = stop_ff;
      held_in       = '0;
      held_valid_in = 1'b0;
      if (!stop_ff) begin
         if (pair) begin
            if (fit_all) begin
               cnt = 3'd4;
            end else begin
               stop_in = 1'b1;
            end
         end else if (held_valid_ff && !fit_held) begin
            stop_in = 1'b1;
         end else if (hold_cur) begin
            cnt           = held_valid_ff ? 3'd3 : 3'd0;
            held_in       = req_code_unit;
            held_valid_in = 1'b1;
         end else if (fit_all) begin
            cnt = need_all;
         end else begin
            stop_in = 1'b1;
            cnt     = held_valid_ff ? 3'd3 : 3'd0;
         end
      end
      if (req_last_unit) begin
         bw_in = '0;
      end else begin
         bw_in = bw_ff + 32'(cnt);
      end
   end

   assign cur_b  = unit_bytes(req_code_unit);
   assign held_b = unit_bytes(held_ff);
   assign pair_b = pair_bytes(held_ff, req_code_unit);

   always_comb begin
      bytes = '0;
      if (pair) begin
         bytes[3:0] = pair_b;
      end else if (held_valid_ff) begin
         bytes[2:0] = held_b;
         bytes[5:3] = cur_b;
      end else begin
         bytes[2:0] = cur_b;
      end
   end

   assign q_push       = accept && ((cnt != 3'd0) || req_last_unit);
   assign q_data.bytes = bytes;
   assign q_data.count = cnt;
   assign q_data.last  = req_last_unit;
   assign q_data.hit   = stop_in;
   assign q_data.base  = bw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         bw_ff         <= '0;
         stop_ff       <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (accept) begin
            // The end of a string returns every piece of string state to zero.
            held_ff       <= req_last_unit ? 16'h0000 : held_in;
            held_valid_ff <= held_valid_in && !req_last_unit;
            bw_ff         <= bw_in;
            stop_ff       <= stop_in && !req_last_unit;
         end
      end
   end

endmodule

>>> design/u16m8_queue.sv
// Small queue of classified entries between the front end and the byte serializer.
module u16m8_queue
   import u16m8_pkg::*;
#(
   parameter int unsigned Depth = U16M8_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  qent_type push_data,
   input  logic     pop,
   output qent_type head,
   output logic     full,
   output logic     empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   qent_type            mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   assign full  = count_ff == CntW'(Depth);
   assign empty = count_ff == '0;
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> design/u16m8_back.sv
// Back end: walks the head entry one byte per unstalled cycle into the result register.
module u16m8_back
   import u16m8_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  qent_type    head,
   input  logic        q_empty,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_string_done,
   output logic [31:0] rsp_total_bytes,
   output logic        rsp_capacity_hit
);

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff;
   logic [7:0]  byte_ff;
   logic        bvalid_ff, run_ff, done_ff, hit_ff;
   logic [31:0] total_ff;

   logic        adv, take, bare, fin;
   logic [2:0]  last_idx;

   assign adv      = !valid_ff || rsp_ready;
   assign take     = adv && !q_empty;
   assign bare     = head.count == 3'd0;
   // An entry without bytes is the bare end-of-string report: one result.
   assign last_idx = bare ? 3'd0 : head.count - 3'd1;
   assign fin      = idx_ff == last_idx;
   assign idx_in   = fin ? 3'd0 : idx_ff + 3'd1;
   assign q_pop    = take && fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (adv) begin
         valid_ff <= !q_empty;
         if (!q_empty) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff   <= bare ? 8'h00 : head.bytes[idx_ff];
         bvalid_ff <= !bare;
         run_ff    <= fin;
         done_ff   <= fin && head.last;
         total_ff  <= bare ? head.base : head.base + 32'(idx_ff) + 32'd1;
         hit_ff    <= head.hit;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvalid_ff;
   assign rsp_last_of_run  = run_ff;
   assign rsp_string_done  = done_ff;
   assign rsp_total_bytes  = total_ff;
   assign rsp_capacity_hit = hit_ff;

endmodule

>>> design/utf16_to_mutf8_encoder_top.sv
// Top level of the UTF-16 to modified UTF-8 encoder.
//
//   Channel  Ports                                  Direction  Moves
//   req      req_valid/req_ready, code unit, last   in         one UTF-16 code unit
//   rsp      rsp_valid/rsp_ready, byte and status   out        one output byte or end report
//   csr      csr_wr_en, csr_wr_data                 in         byte capacity, no wait
//
// Each code unit gives zero to six results, one per cycle from the result register while
// rsp_ready does not stall it; a unit that is held back or comes after the capacity stop
// gives none, unless it ends the string, in which case it gives the bare end report.
// The front end classifies a unit in the cycle it is accepted and takes the next unit at
// once while the queue has room, so input and output stall independently.
// Synchronous reset clears the capacity register, the string state, the queue and the
// result valid flag.
module utf16_to_mutf8_encoder_top
   import u16m8_pkg::*;
#(
   parameter int unsigned QueueDepth = U16M8_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_code_unit,
   input  logic        req_last_unit,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic        rsp_string_done,
   output logic [31:0] rsp_total_bytes,
   output logic        rsp_capacity_hit,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   qent_type push_data, head;
   logic     push, pop, full, empty;

   u16m8_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_code_unit(req_code_unit),
      .req_last_unit(req_last_unit),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .q_full       (full),
      .q_push       (push),
      .q_data       (push_data)
   );

   u16m8_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   u16m8_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (empty),
      .q_pop           (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_string_done (rsp_string_done),
      .rsp_total_bytes (rsp_total_bytes),
      .rsp_capacity_hit(rsp_capacity_hit)
   );

endmodule

>>> design/u16m8_checker.sv
// Port-level checks for the encoder top level, attached by a bind statement.
module u16m8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_byte_valid,
   input logic        rsp_last_of_run,
   input logic        rsp_string_done,
   input logic [31:0] rsp_total_bytes,
   input logic        rsp_capacity_hit
);

   // A stalled result transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_total_bytes) && $stable(rsp_string_done)
         && $stable(rsp_byte_valid) && $stable(rsp_last_of_run)
         && $stable(rsp_capacity_hit))
      else $error("result changed while stalled");

   // The bare end report carries no byte and closes both the unit and the string.
   a_bare_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'h00 && rsp_last_of_run
         && rsp_string_done)
      else $error("malformed bare end report");

   // The end of a string is always the last result of its unit.
   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_string_done |-> rsp_last_of_run)
      else $error("string ended in the middle of a unit");

   // A result that carries a byte counts at least that byte.
   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_total_bytes != 32'd0)
      else $error("byte result with zero total");

endmodule

bind utf16_to_mutf8_encoder_top u16m8_checker u_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for the UTF-16 to modified UTF-8 encoder top level.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] HIGH_MIN = 16'hD800;
   localparam logic [15:0] HIGH_MAX = 16'hDBFF;
   localparam logic [15:0] LOW_MIN  = 16'hDC00;
   localparam logic [15:0] LOW_MAX  = 16'hDFFF;
   localparam int          UNITS_PER_PHASE = 55;
   localparam int          LONG_HOLD_CYCLES = 60;
   localparam int          PRESSURE_PHASE = 4;
   localparam int          NUM_PHASES = 8;

   // Directed units: {last_unit, code_unit}.
   localparam logic [16:0] DIRECTED [22] = '{
      {1'b0, 16'h0000}, {1'b0, 16'h0041}, {1'b0, 16'h007F}, {1'b0, 16'h0080},
      {1'b0, 16'h07FF}, {1'b0, 16'h0800}, {1'b1, 16'hFFFF},
      {1'b0, 16'hD800}, {1'b0, 16'hDC00}, {1'b0, 16'hDBFF}, {1'b1, 16'hDFFF},
      {1'b0, 16'hD83D}, {1'b0, 16'h0041}, {1'b0, 16'hD800}, {1'b0, 16'hD801},
      {1'b0, 16'hDC05}, {1'b0, 16'hDC00}, {1'b1, 16'hDBFF},
      {1'b0, 16'hD800}, {1'b1, 16'hD800},
      {1'b0, 16'hAAAA}, {1'b1, 16'h5555}
   };

   typedef struct {
      logic [7:0]  data;
      logic        carries_byte;
      logic        run_end;
      logic        str_end;
      logic [31:0] count;
      logic        hit;
   } mutf8_result_type;

   class mutf8_scoreboard;
      logic [31:0]      capacity;
      logic [15:0]      held_unit;
      logic             held;
      logic [31:0]      written;
      logic             stopped;
      int               errors;
      mutf8_result_type pending_bytes[$];
      logic [7:0]       run_byte[$];
      logic [31:0]      run_total[$];

      function new();
         capacity  = '0;
         held_unit = '0;
         held      = 1'b0;
         written   = '0;
         stopped   = 1'b0;
         errors    = 0;
      endfunction

      task flag_mismatch(input string what);
         $display("ERROR at %0t: %s", $realtime, what);
         errors++;
      endtask

      // A character goes out whole or not at all; the first misfit freezes the string.
      function void put_char(input logic [31:0] seq, input int n);
         if (stopped) return;
         if ({1'b0, written} + 33'(n) > {1'b0, capacity}) begin
            stopped = 1'b1;
            return;
         end
         for (int i = 0; i < n; i++) begin
            written++;
            run_byte.push_back(seq[31 - 8*i -: 8]);
            run_total.push_back(written);
         end
      endfunction

      function void put_unit(input logic [15:0] u);
         if (u == 16'h0000) begin
            put_char({8'hC0, 8'h80, 16'h0000}, 2);
         end else if (u < 16'h0080) begin
            put_char({u[7:0], 24'h000000}, 1);
         end else if (u < 16'h0800) begin
            put_char({3'b110, u[10:6], 2'b10, u[5:0], 16'h0000}, 2);
         end else begin
            put_char({4'b1110, u[15:12], 2'b10, u[11:6], 2'b10, u[5:0], 8'h00}, 3);
         end
      endfunction

      function void put_pair(input logic [15:0] hi, input logic [15:0] lo);
         logic [20:0] cp;
         cp = {1'b0, hi[9:0], lo[9:0]} + 21'h10000;
         put_char({5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]}, 4);
      endfunction

      function void note_unit(input logic [15:0] u, input logic last);
         logic             bare;
         mutf8_result_type r;
         run_byte.delete();
         run_total.delete();
         bare = 1'b0;
         if (!stopped) begin
            if (held && u >= LOW_MIN && u <= LOW_MAX) begin
               put_pair(held_unit, u);
               held      = 1'b0;
               held_unit = '0;
            end else begin
               if (held) begin
                  put_unit(held_unit);
                  held      = 1'b0;
                  held_unit = '0;
               end
               if (!stopped) begin
                  if (u >= HIGH_MIN && u <= HIGH_MAX && !last) begin
                     held_unit = u;
                     held      = 1'b1;
                  end else begin
                     put_unit(u);
                  end
               end
            end
         end
         if (stopped) begin
            held      = 1'b0;
            held_unit = '0;
         end
         if (last && run_byte.size() == 0) begin
            run_byte.push_back(8'h00);
            run_total.push_back(written);
            bare = 1'b1;
         end
         for (int k = 0; k < run_byte.size(); k++) begin
            r.data         = run_byte[k];
            r.carries_byte = !bare;
            r.run_end      = (k == run_byte.size() - 1);
            r.str_end      = r.run_end && last;
            r.count        = run_total[k];
            r.hit          = stopped;
            pending_bytes.push_back(r);
         end
         if (last) begin
            held      = 1'b0;
            held_unit = '0;
            written   = '0;
            stopped   = 1'b0;
         end
      endfunction

      task check_byte(input logic [7:0] data, input logic carries_byte, input logic run_end,
                      input logic str_end, input logic [31:0] count, input logic hit);
         mutf8_result_type e;
         if (pending_bytes.size() == 0) begin
            flag_mismatch($sformatf("unexpected result byte %02h total %0d", data, count));
            return;
         end
         e = pending_bytes.pop_front();
         if (data !== e.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", data, e.data));
         if (carries_byte !== e.carries_byte)
            flag_mismatch($sformatf("byte_valid %b, want %b", carries_byte, e.carries_byte));
         if (run_end !== e.run_end)
            flag_mismatch($sformatf("last_of_run %b, want %b", run_end, e.run_end));
         if (str_end !== e.str_end)
            flag_mismatch($sformatf("string_done %b, want %b", str_end, e.str_end));
         if (count !== e.count)
            flag_mismatch($sformatf("total_bytes %0d, want %0d", count, e.count));
         if (hit !== e.hit)
            flag_mismatch($sformatf("capacity_hit %b, want %b", hit, e.hit));
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_code_unit;
   logic        req_last_unit;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_run;
   logic        rsp_string_done;
   logic [31:0] rsp_total_bytes;
   logic        rsp_capacity_hit;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   mutf8_scoreboard sb = new();
   bit              idle_on = 1'b1;
   bit              long_hold_req = 1'b0;
   int              stall_left = 0;

   utf16_to_mutf8_encoder_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_unit   (req_code_unit),
      .req_last_unit   (req_last_unit),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_string_done (rsp_string_done),
      .rsp_total_bytes (rsp_total_bytes),
      .rsp_capacity_hit(rsp_capacity_hit),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Result side: check every transaction and choose the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_byte(rsp_out_byte, rsp_byte_valid, rsp_last_of_run, rsp_string_done,
                       rsp_total_bytes, rsp_capacity_hit);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left = LONG_HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(1, 4) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

   task automatic send_unit(input logic [15:0] u, input logic last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_unit <= u;
      req_last_unit <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_unit(u, last);
   endtask

   // Drop valid and let every outstanding result drain before touching the register.
   task automatic drain_bytes();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.capacity = value;
   endtask

   function automatic logic [15:0] pick_bmp();
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return 16'h0000;
      else if (c < 4) return 16'($urandom_range(16'h0001, 16'h007F));
      else if (c < 6) return 16'($urandom_range(16'h0080, 16'h07FF));
      else if (c < 8) return 16'($urandom_range(16'h0800, 16'hD7FF));
      else return 16'($urandom_range(16'hE000, 16'hFFFF));
   endfunction

   // Mostly well-formed strings with surrogate pairs, plus lone surrogates and raw noise.
   task automatic send_strings(input int n_units);
      int          sent;
      int          len;
      int          kind;
      logic [15:0] hi;
      sent = 0;
      while (sent < n_units) begin
         len = $urandom_range(1, 7);
         for (int k = 0; k < len; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 25 && k < len - 1) begin
               hi = 16'($urandom_range(HIGH_MIN, HIGH_MAX));
               send_unit(hi, 1'b0);
               k++;
               send_unit(16'($urandom_range(LOW_MIN, LOW_MAX)), k == len - 1);
               sent += 2;
            end else begin
               if (kind < 85) begin
                  send_unit(pick_bmp(), k == len - 1);
               end else if (kind < 90) begin
                  send_unit(16'($urandom_range(HIGH_MIN, HIGH_MAX)), k == len - 1);
               end else if (kind < 95) begin
                  send_unit(16'($urandom_range(LOW_MIN, LOW_MAX)), k == len - 1);
               end else begin
                  send_unit(16'($urandom_range(0, 16'hFFFF)), k == len - 1);
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      logic [31:0] caps [NUM_PHASES];
      caps = '{32'h0000_0000, 32'h0000_0002, 32'h0000_0003, 32'h0000_0005,
               32'h0000_0008, 32'($urandom_range(6, 24)), 32'h0000_0040, 32'hFFFF_FFFF};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_code_unit = '0;
      req_last_unit = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_capacity(32'hFFFF_FFFF);
      foreach (DIRECTED[i]) send_unit(DIRECTED[i][15:0], DIRECTED[i][16]);
      drain_bytes();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_capacity(caps[p]);
         if (p == PRESSURE_PHASE) long_hold_req = 1'b1;
         if (p == NUM_PHASES - 1) idle_on = 1'b0;
         send_strings(UNITS_PER_PHASE);
         drain_bytes();
      end
      repeat (12) @(posedge clock);

      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
